### hw/rtl/ahd_pkg.sv
// Shared types, constants and the byte-wide CRC-16 update for the HDLC deframer.
// No dependencies; imported by every module of the block.
package ahd_pkg;

    localparam logic [7:0]  HDLC_FLAG         = 8'h7E;
    localparam logic [15:0] CRC_POLY          = 16'h8408;
    localparam logic [15:0] CRC_PRESET        = 16'hFFFF;
    localparam logic [15:0] CRC_RESIDUE_RESET = 16'hF0B8;
    localparam logic [2:0]  STUFF_RUN         = 3'd5;
    localparam logic [2:0]  ONES_MAX          = 3'd7;
    localparam logic [3:0]  DELAY_LEN         = 4'd8;
    localparam logic [8:0]  COUNT_CAP         = 9'd256;

    typedef enum logic [1:0] {
        STATUS_GOOD    = 2'd0,
        STATUS_BAD     = 2'd1,
        STATUS_NO_FLAG = 2'd2
    } status_t;

    typedef struct packed {
        logic raw_bit;
        logic first_bit;
        logic last_bit;
    } item_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       frame_done;
        status_t    status;
        logic [8:0] byte_count;
    } result_t;

    // Reflected CRC-16, byte fed bit 0 first.
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            if (c[0] ^ data[i])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

### hw/rtl/ahd_in_stage.sv
// Input register stage of the deframer: holds one bit request until the core takes it.
// Depends on ahd_pkg (item_t).
module ahd_in_stage
    import ahd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  take,
    output logic  held_valid,
    output item_t held_item
);

    logic  valid_reg;
    item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

### hw/rtl/ahd_core.sv
// Decoder state and per-bit step: NRZI decode, flag hunt, delay line, unstuff, byte, CRC.
// Depends on ahd_pkg (types, constants, crc_update).
module ahd_core
    import ahd_pkg::*;
#(
    parameter int MAX_FRAME_BITS = 2048
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  item_t       item,
    input  logic [15:0] crc_residue,
    output logic        res_valid,
    output result_t     res
);

    localparam int CNT_W = $clog2(MAX_FRAME_BITS + 1);
    localparam logic [CNT_W-1:0] BIT_LIMIT = CNT_W'(MAX_FRAME_BITS);

    logic             prev_raw_reg,  prev_raw_next,  prev_raw_cur;
    logic [7:0]       sync_reg,      sync_next,      sync_cur;
    logic             in_frame_reg,  in_frame_next,  in_frame_cur;
    logic [7:0]       flagw_reg,     flagw_next,     flagw_cur;
    logic [7:0]       delay_reg,     delay_next,     delay_cur;
    logic [3:0]       fill_reg,      fill_next,      fill_cur;
    logic [2:0]       ones_reg,      ones_next,      ones_cur;
    logic [2:0]       pos_reg,       pos_next,       pos_cur;
    logic [7:0]       accum_reg,     accum_next,     accum_cur;
    logic [15:0]      crc_reg,       crc_next,       crc_cur;
    logic [8:0]       bytes_reg,     bytes_next,     bytes_cur;
    logic [CNT_W-1:0] count_reg,     count_next,     count_cur;
    logic             finished_reg,  finished_next,  finished_cur;

    always_comb
    begin
        logic       b;
        logic       oldest;
        logic       drop;
        logic       have_byte;
        logic       done;
        logic [7:0] full_byte;
        status_t    stat;

        // A first bit restarts the decoder before the bit is handled.
        if (item.first_bit)
        begin
            prev_raw_cur = 1'b1;
            sync_cur     = '0;
            in_frame_cur = 1'b0;
            flagw_cur    = '0;
            delay_cur    = '0;
            fill_cur     = '0;
            ones_cur     = '0;
            pos_cur      = '0;
            accum_cur    = '0;
            crc_cur      = CRC_PRESET;
            bytes_cur    = '0;
            count_cur    = '0;
            finished_cur = 1'b0;
        end
        else
        begin
            prev_raw_cur = prev_raw_reg;
            sync_cur     = sync_reg;
            in_frame_cur = in_frame_reg;
            flagw_cur    = flagw_reg;
            delay_cur    = delay_reg;
            fill_cur     = fill_reg;
            ones_cur     = ones_reg;
            pos_cur      = pos_reg;
            accum_cur    = accum_reg;
            crc_cur      = crc_reg;
            bytes_cur    = bytes_reg;
            count_cur    = count_reg;
            finished_cur = finished_reg;
        end

        prev_raw_next = prev_raw_cur;
        sync_next     = sync_cur;
        in_frame_next = in_frame_cur;
        flagw_next    = flagw_cur;
        delay_next    = delay_cur;
        fill_next     = fill_cur;
        ones_next     = ones_cur;
        pos_next      = pos_cur;
        accum_next    = accum_cur;
        crc_next      = crc_cur;
        bytes_next    = bytes_cur;
        count_next    = count_cur;
        finished_next = finished_cur;

        b         = ~(item.raw_bit ^ prev_raw_cur);
        oldest    = delay_cur[7];
        drop      = 1'b0;
        have_byte = 1'b0;
        done      = 1'b0;
        full_byte = accum_cur | (8'(oldest) << pos_cur);
        stat      = STATUS_GOOD;

        if (!finished_cur)
        begin
            if (count_cur < BIT_LIMIT)
            begin
                prev_raw_next = item.raw_bit;
                count_next    = count_cur + CNT_W'(1);
                if (!in_frame_cur)
                begin
                    sync_next = {sync_cur[6:0], b};
                    if ({sync_cur[6:0], b} == HDLC_FLAG)
                    begin
                        in_frame_next = 1'b1;
                        flagw_next    = '0;
                        delay_next    = '0;
                        fill_next     = '0;
                    end
                end
                else
                begin
                    if (fill_cur >= DELAY_LEN)
                    begin
                        // Unstuff the bit leaving the delay line.
                        if (oldest)
                        begin
                            if (ones_cur < ONES_MAX)
                                ones_next = ones_cur + 3'd1;
                        end
                        else
                        begin
                            drop      = (ones_cur == STUFF_RUN);
                            ones_next = '0;
                        end
                        if (!drop)
                        begin
                            accum_next = full_byte;
                            pos_next   = pos_cur + 3'd1;
                            if (pos_cur == 3'd7)
                            begin
                                have_byte  = 1'b1;
                                crc_next   = crc_update(crc_cur, full_byte);
                                accum_next = '0;
                                if (bytes_cur < COUNT_CAP)
                                    bytes_next = bytes_cur + 9'd1;
                            end
                        end
                    end
                    else
                    begin
                        fill_next = fill_cur + 4'd1;
                    end
                    delay_next = {delay_cur[6:0], b};
                    flagw_next = {flagw_cur[6:0], b};
                    if ({flagw_cur[6:0], b} == HDLC_FLAG)
                    begin
                        done = 1'b1;
                        stat = (crc_next == crc_residue) ? STATUS_GOOD : STATUS_BAD;
                    end
                end
            end
            if (!done && item.last_bit)
            begin
                done = 1'b1;
                stat = STATUS_NO_FLAG;
            end
            if (done)
                finished_next = 1'b1;
        end

        res_valid      = have_byte || done;
        res.byte_valid = have_byte;
        res.data_byte  = have_byte ? full_byte : 8'd0;
        res.frame_done = done;
        res.status     = done ? stat : STATUS_GOOD;
        res.byte_count = done ? bytes_next : 9'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg <= 1'b1;
            sync_reg     <= '0;
            in_frame_reg <= 1'b0;
            flagw_reg    <= '0;
            delay_reg    <= '0;
            fill_reg     <= '0;
            ones_reg     <= '0;
            pos_reg      <= '0;
            accum_reg    <= '0;
            crc_reg      <= CRC_PRESET;
            bytes_reg    <= '0;
            count_reg    <= '0;
            finished_reg <= 1'b0;
        end
        else if (step)
        begin
            prev_raw_reg <= prev_raw_next;
            sync_reg     <= sync_next;
            in_frame_reg <= in_frame_next;
            flagw_reg    <= flagw_next;
            delay_reg    <= delay_next;
            fill_reg     <= fill_next;
            ones_reg     <= ones_next;
            pos_reg      <= pos_next;
            accum_reg    <= accum_next;
            crc_reg      <= crc_next;
            bytes_reg    <= bytes_next;
            count_reg    <= count_next;
            finished_reg <= finished_next;
        end
    end

endmodule

### hw/rtl/ahd_out_stage.sv
// Result register of the deframer: holds one result request until the sink takes it.
// Depends on ahd_pkg (result_t).
module ahd_out_stage
    import ahd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_res,
    output logic    can_load,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    valid_reg;
    result_t res_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= load_res;
        end
    end

endmodule

### hw/rtl/ais_hdlc_nrzi_deframer.sv
// Top level of the NRZI HDLC deframer: handshake stages, decoder core, APB register.
// Depends on ahd_pkg, ahd_in_stage, ahd_core, ahd_out_stage.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------------------
//  in       | in_valid / in_ready      | raw_bit, first_bit, last_bit
//  out      | out_valid / out_ready    | byte_valid, data_byte, frame_done, status,
//           |                          | byte_count
//  apb      | psel, penable, pready    | pwrite, paddr, pwdata, prdata (crc_residue @0)
//
// One line bit per clock while out_ready does not stall. A request is held in the
// input register while the core works it, and any result is loaded into the output
// register when the core steps, which raises out_valid until the sink takes it.
// Bits that produce no result (most of them) leave nothing in the output stage.
// A stalled out_ready holds the core step; the input register still takes one
// more request, then in_ready drops until the result is taken.
// rst_n clears all decoder state and sets crc_residue to 0xF0B8; first_bit
// restarts the decoder without touching crc_residue.
module ais_hdlc_nrzi_deframer
    import ahd_pkg::*;
#(
    parameter int MAX_FRAME_BITS = 2048
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        raw_bit,
    input  logic        first_bit,
    input  logic        last_bit,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        byte_valid,
    output logic [7:0]  data_byte,
    output logic        frame_done,
    output logic [1:0]  status,
    output logic [8:0]  byte_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    item_t       in_item;
    item_t       held_item;
    logic        held_valid;
    logic        step;
    logic        can_load;
    logic        res_valid;
    result_t     core_res;
    result_t     out_res;
    logic [15:0] residue_reg;

    assign in_item = '{raw_bit: raw_bit, first_bit: first_bit, last_bit: last_bit};

    // The core advances only when any result it makes has somewhere to go.
    assign step = held_valid && can_load;

    // APB register: crc_residue at word 0, anything above it reads zero.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, residue_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            residue_reg <= CRC_RESIDUE_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
        begin
            residue_reg <= pwdata[15:0];
        end
    end

    ahd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (step),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    ahd_core #(
        .MAX_FRAME_BITS (MAX_FRAME_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (held_item),
        .crc_residue (residue_reg),
        .res_valid   (res_valid),
        .res         (core_res)
    );

    ahd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && res_valid),
        .load_res  (core_res),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign byte_valid = out_res.byte_valid;
    assign data_byte  = out_res.data_byte;
    assign frame_done = out_res.frame_done;
    assign status     = out_res.status;
    assign byte_count = out_res.byte_count;

    // A result always carries a byte, an end of frame, or both.
    a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_valid || frame_done))
        else $error("result with neither byte nor frame end");

    // End-of-frame fields stay zero on a byte-only result.
    a_no_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !frame_done) |-> (status == STATUS_GOOD && byte_count == 9'd0))
        else $error("status or count set without frame end");

    // Byte count saturates and status never takes the unused code.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_count <= COUNT_CAP && status <= STATUS_NO_FLAG))
        else $error("byte count or status out of range");

    // The core never steps while the output register is full and stalled.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !step)
        else $error("core stepped into a stalled output register");

endmodule
